// ----- hdl/ets_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

  localparam int unsigned LENGTH_W = 16;
  localparam int unsigned OFFSET_W = 32;
  localparam int unsigned LINE_W   = 32;

  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  // Literal names, left aligned, first letter in the top byte
  localparam logic [63:0] TEXT_I       = {"I", 56'd0};
  localparam logic [63:0] TEXT_PI      = {"Pi", 48'd0};
  localparam logic [63:0] TEXT_EULER   = {"Euler", 24'd0};
  localparam logic [63:0] TEXT_CATALAN = {"Catalan", 8'd0};

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_COMMENT
  } scan_mode_t;

  typedef enum logic [2:0] {
    KIND_IDENT   = 3'd0,
    KIND_LITERAL = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_SINGLE  = 3'd3,
    KIND_END     = 3'd4
  } token_kind_t;

  typedef enum logic [2:0] {
    LIT_NONE    = 3'd0,
    LIT_I       = 3'd1,
    LIT_PI      = 3'd2,
    LIT_EULER   = 3'd3,
    LIT_CATALAN = 3'd4
  } lit_code_t;

  typedef struct packed {
    token_kind_t         kind;
    lit_code_t           code;
    logic [7:0]          char_byte;
    logic [LENGTH_W-1:0] length;
    logic [OFFSET_W-1:0] start;
    logic [LINE_W-1:0]   line;
  } token_t;

  // Results of one accepted byte: count says how many of first, second hold
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } token_pair_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b inside {["a":"z"], ["A":"Z"]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b inside {["0":"9"]});
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CHAR_SPACE) || (b inside {[8'h09:8'h0D]});
  endfunction

  function automatic logic [2:0] lit_len(input lit_code_t code);
    logic [2:0] len;
    case (code)
      LIT_I:       len = 3'd1;
      LIT_PI:      len = 3'd2;
      LIT_EULER:   len = 3'd5;
      LIT_CATALAN: len = 3'd7;
      default:     len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] lit_char(input lit_code_t code, input logic [2:0] idx);
    logic [63:0] text;
    case (code)
      LIT_I:       text = TEXT_I;
      LIT_PI:      text = TEXT_PI;
      LIT_EULER:   text = TEXT_EULER;
      LIT_CATALAN: text = TEXT_CATALAN;
      default:     text = '0;
    endcase
    return text[{~idx, 3'b000} +: 8];
  endfunction

  function automatic lit_code_t lit_start(input logic [7:0] b);
    lit_code_t code;
    case (b)
      "I":     code = LIT_I;
      "P":     code = LIT_PI;
      "E":     code = LIT_EULER;
      "C":     code = LIT_CATALAN;
      default: code = LIT_NONE;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ets_char_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ets_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       end_of_input;

  modport source (output valid, output char_byte, output end_of_input, input ready);
  modport sink (input valid, input char_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ----- hdl/ets_token_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface ets_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  token_kind;
  logic [2:0]  literal_code;
  logic [7:0]  token_char;
  logic [15:0] token_length;
  logic [31:0] start_offset;
  logic [31:0] line_number;

  modport source (
    output valid, output token_kind, output literal_code, output token_char,
    output token_length, output start_offset, output line_number, input ready
  );
  modport sink (
    input valid, input token_kind, input literal_code, input token_char,
    input token_length, input start_offset, input line_number, output ready
  );
endinterface

`default_nettype wire

// ----- hdl/ets_lexer.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ets_lexer
  import ets_pkg::*;
#(
  parameter int unsigned LENGTH_BITS   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  char_byte,
  input  wire logic        end_of_input,
  output token_pair_t      results
);

  scan_mode_t               mode, mode_next;
  logic [LENGTH_BITS-1:0]   run_length, run_length_next;
  logic [POSITION_BITS-1:0] run_start, run_start_next;
  logic [7:0]               run_first_char, run_first_char_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [LINE_W-1:0]        line_count, line_count_next;
  lit_code_t                literal_candidate, literal_candidate_next;
  logic [LINE_W-1:0]        run_start_line, run_start_line_next;

  logic              b_alpha, b_digit, b_space, b_alnum, b_numeric, b_newline;
  logic              run_open, run_ends, run_is_literal, cand_keeps;
  logic [LINE_W-1:0] line_inc;
  token_t            run_tok, byte_tok, end_tok;

  assign b_alpha   = is_alpha(char_byte);
  assign b_digit   = is_digit(char_byte);
  assign b_space   = is_space(char_byte);
  assign b_alnum   = b_alpha || b_digit;
  assign b_numeric = b_digit || (char_byte == CHAR_DOT);
  assign b_newline = (char_byte == CHAR_LF) || (char_byte == CHAR_CR);

  assign run_open = (mode == MODE_IDENT) || (mode == MODE_NUMBER);
  assign run_ends = ((mode == MODE_IDENT) && !b_alnum) ||
                    ((mode == MODE_NUMBER) && !b_numeric);

  assign line_inc = (line_count == '1) ? line_count : line_count + 1'b1;

  assign run_is_literal = (mode == MODE_IDENT) && (literal_candidate != LIT_NONE) &&
                          (run_length == LENGTH_BITS'(lit_len(literal_candidate)));

  // The candidate survives while the byte matches the name at this position
  assign cand_keeps = (literal_candidate != LIT_NONE) &&
                      (run_length < LENGTH_BITS'(lit_len(literal_candidate))) &&
                      (lit_char(literal_candidate, run_length[2:0]) == char_byte);

  always_comb begin
    run_tok.kind      = run_is_literal ? KIND_LITERAL :
                        ((mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT);
    run_tok.code      = run_is_literal ? literal_candidate : LIT_NONE;
    run_tok.char_byte = run_first_char;
    run_tok.length    = LENGTH_W'(run_length);
    run_tok.start     = OFFSET_W'(run_start);
    run_tok.line      = run_start_line;

    byte_tok.kind      = KIND_SINGLE;
    byte_tok.code      = LIT_NONE;
    byte_tok.char_byte = char_byte;
    byte_tok.length    = LENGTH_W'(1);
    byte_tok.start     = OFFSET_W'(byte_position);
    byte_tok.line      = line_count;

    end_tok.kind      = KIND_END;
    end_tok.code      = LIT_NONE;
    end_tok.char_byte = '0;
    end_tok.length    = '0;
    end_tok.start     = OFFSET_W'(byte_position);
    end_tok.line      = line_count;
  end

  // Next state
  always_comb begin : next_state
    logic between;
    between                = (mode == MODE_IDLE);
    mode_next              = mode;
    run_length_next        = run_length;
    run_start_next         = run_start;
    run_first_char_next    = run_first_char;
    byte_position_next     = byte_position;
    line_count_next        = line_count;
    literal_candidate_next = literal_candidate;
    run_start_line_next    = run_start_line;

    if (take) begin
      if (end_of_input) begin
        mode_next              = MODE_IDLE;
        run_length_next        = '0;
        run_start_next         = '0;
        run_first_char_next    = '0;
        byte_position_next     = '0;
        line_count_next        = '0;
        literal_candidate_next = LIT_NONE;
        run_start_line_next    = '0;
      end else begin
        byte_position_next = byte_position + 1'b1;
        if (mode == MODE_COMMENT) begin
          // the ending newline is consumed here and counted once
          if (b_newline) begin
            line_count_next = line_inc;
            mode_next       = MODE_IDLE;
          end
        end else begin
          if (run_open && !run_ends) begin
            literal_candidate_next = cand_keeps ? literal_candidate : LIT_NONE;
            run_length_next = (run_length == '1) ? run_length : run_length + 1'b1;
          end
          if (run_ends) begin
            between   = 1'b1;
            mode_next = MODE_IDLE;
          end
          if (between) begin
            if (b_space) begin
              if (char_byte == CHAR_LF) begin
                line_count_next = line_inc;
              end
            end else if (b_alpha || b_numeric) begin
              mode_next              = b_alpha ? MODE_IDENT : MODE_NUMBER;
              run_length_next        = LENGTH_BITS'(1);
              run_start_next         = byte_position;
              run_first_char_next    = char_byte;
              run_start_line_next    = line_count;
              literal_candidate_next = b_alpha ? lit_start(char_byte) : LIT_NONE;
            end else if (char_byte == CHAR_HASH) begin
              mode_next = MODE_COMMENT;
            end
          end
        end
      end
    end
  end

  // Results of this byte
  always_comb begin : result_out
    logic single;
    single = !b_space && !b_alpha && !b_numeric && (char_byte != CHAR_HASH) &&
             ((mode == MODE_IDLE) || run_ends);
    results.count  = 2'd0;
    results.first  = run_tok;
    results.second = end_tok;
    if (take) begin
      if (end_of_input) begin
        if (run_open) begin
          results.count = 2'd2;
        end else begin
          results.count = 2'd1;
          results.first = end_tok;
        end
      end else if (mode != MODE_COMMENT) begin
        if (run_ends) begin
          results.count  = single ? 2'd2 : 2'd1;
          results.second = byte_tok;
        end else if (single) begin
          results.count = 2'd1;
          results.first = byte_tok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= MODE_IDLE;
      run_length        <= '0;
      run_start         <= '0;
      run_first_char    <= '0;
      byte_position     <= '0;
      line_count        <= '0;
      literal_candidate <= LIT_NONE;
      run_start_line    <= '0;
    end else begin
      mode              <= mode_next;
      run_length        <= run_length_next;
      run_start         <= run_start_next;
      run_first_char    <= run_first_char_next;
      byte_position     <= byte_position_next;
      line_count        <= line_count_next;
      literal_candidate <= literal_candidate_next;
      run_start_line    <= run_start_line_next;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/ets_result_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ets_result_queue
  import ets_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire token_pair_t  results,
  output logic              space,
  ets_token_if.source       token_out
);

  localparam int unsigned DEPTH = 4;

  token_t     slots [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       pop;

  assign pop   = token_out.valid && token_out.ready;
  // room for the two results a byte can cause
  assign space = (count <= 3'(DEPTH - 2));

  assign token_out.valid        = (count != 3'd0);
  assign token_out.token_kind   = slots[rd_ptr].kind;
  assign token_out.literal_code = slots[rd_ptr].code;
  assign token_out.token_char   = slots[rd_ptr].char_byte;
  assign token_out.token_length = slots[rd_ptr].length;
  assign token_out.start_offset = slots[rd_ptr].start;
  assign token_out.line_number  = slots[rd_ptr].line;

  always_ff @(posedge clk) begin
    if (results.count != 2'd0) begin
      slots[wr_ptr] <= results.first;
    end
    if (results.count == 2'd2) begin
      slots[wr_ptr + 2'd1] <= results.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + results.count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(results.count) - 3'(pop);
    end
  end

endmodule

`default_nettype wire

// ----- hdl/expression_token_scanner.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Streaming lexer for arithmetic expression text.
// char_in carries one byte per transaction, or an end-of-input mark. Each
// transaction yields zero, one or two tokens on token_out: kind, literal code,
// first byte, length, start offset and the line count at the token start.
// Both channels move a transaction when valid and ready are high at a clock.
// A token is written into the result queue when the byte that ends it is accepted,
// and reaches token_out after the tokens queued before it. Throughput: one byte per
// cycle while char_in.ready is high. The state update for a byte is character-class
// logic and counters; tokens wait in a four-entry queue, and char_in.ready is high
// while that queue has room for two tokens. A byte that causes two tokens needs two
// output transactions, so a long stream of such bytes is held back by char_in.ready.
// When token_out is stalled, tokens collect in the queue and char_in.ready
// drops once fewer than two entries remain free; nothing is lost.
// Reset (rst, synchronous) empties the queue and clears offset, line count
// and scan state. An end-of-input mark does the same to the scan state after
// the final run token and the end token are queued.
module expression_token_scanner
  import ets_pkg::*;
#(
  parameter int unsigned LENGTH_BITS   = 16,
  parameter int unsigned POSITION_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ets_char_if.sink    char_in,
  ets_token_if.source token_out
);

  logic        space;
  logic        take;
  token_pair_t results;

  assign char_in.ready = space;
  assign take          = char_in.valid && space;

  ets_lexer #(
    .LENGTH_BITS   (LENGTH_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_lexer (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .char_byte    (char_in.char_byte),
    .end_of_input (char_in.end_of_input),
    .results      (results)
  );

  ets_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .results   (results),
    .space     (space),
    .token_out (token_out)
  );

endmodule

`default_nettype wire

// ----- bench/expression_token_scanner_tb.sv -----
`timescale 1ns / 1ps

module expression_token_scanner_tb;
  import ets_pkg::*;

  // Tracks scanner state for every accepted byte and holds the tokens it should emit
  class token_scoreboard;
    scan_mode_t          mode;
    logic [LENGTH_W-1:0] run_len;
    logic [OFFSET_W-1:0] run_at;
    logic [OFFSET_W-1:0] pos;
    logic [7:0]          run_char;
    logic [LINE_W-1:0]   lines;
    logic [LINE_W-1:0]   run_line;
    lit_code_t           cand;
    token_t              awaited[$];
    int                  failures;

    function new();
      failures = 0;
      clear_state();
    endfunction

    function void clear_state();
      mode     = MODE_IDLE;
      run_len  = '0;
      run_at   = '0;
      pos      = '0;
      run_char = '0;
      lines    = '0;
      run_line = '0;
      cand     = LIT_NONE;
    endfunction

    static function string name_text(lit_code_t c);
      case (c)
        LIT_I:       return "I";
        LIT_PI:      return "Pi";
        LIT_EULER:   return "Euler";
        LIT_CATALAN: return "Catalan";
        default:     return "";
      endcase
    endfunction

    static function bit letter(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    static function bit digit(logic [7:0] b);
      return b >= "0" && b <= "9";
    endfunction

    static function bit blank(logic [7:0] b);
      return b == CHAR_SPACE || (b >= 8'h09 && b <= CHAR_CR);
    endfunction

    function void push_token(token_kind_t k, lit_code_t c, logic [7:0] ch,
                             logic [LENGTH_W-1:0] len, logic [OFFSET_W-1:0] at,
                             logic [LINE_W-1:0] ln);
      token_t t;
      t.kind      = k;
      t.code      = c;
      t.char_byte = ch;
      t.length    = len;
      t.start     = at;
      t.line      = ln;
      awaited.push_back(t);
    endfunction

    function void close_run();
      token_kind_t k;
      lit_code_t   c;
      string       txt;
      k = (mode == MODE_NUMBER) ? KIND_NUMBER : KIND_IDENT;
      c = LIT_NONE;
      txt = name_text(cand);
      if (mode == MODE_IDENT && cand != LIT_NONE && run_len == txt.len()) begin
        k = KIND_LITERAL;
        c = cand;
      end
      push_token(k, c, run_char, run_len, run_at, run_line);
      mode = MODE_IDLE;
    endfunction

    function void open_run(scan_mode_t m, logic [7:0] b);
      mode     = m;
      run_len  = LENGTH_W'(1);
      run_at   = pos;
      run_char = b;
      run_line = lines;
      cand     = LIT_NONE;
      if (m == MODE_IDENT) begin
        case (b)
          "I":     cand = LIT_I;
          "P":     cand = LIT_PI;
          "E":     cand = LIT_EULER;
          "C":     cand = LIT_CATALAN;
          default: cand = LIT_NONE;
        endcase
      end
    endfunction

    function void grow_run(logic [7:0] b);
      string txt;
      txt = name_text(cand);
      // drop the literal candidate as soon as the text departs from its name
      if (cand != LIT_NONE && !(run_len < txt.len() && txt[run_len] == b))
        cand = LIT_NONE;
      if (run_len != '1)
        run_len++;
    endfunction

    function void bump_line();
      if (lines != '1)
        lines++;
    endfunction

    function void note_input(logic [7:0] b, logic e);
      if (e) begin
        if (mode == MODE_IDENT || mode == MODE_NUMBER)
          close_run();
        push_token(KIND_END, LIT_NONE, 8'h00, '0, pos, lines);
        clear_state();
        return;
      end
      if (mode == MODE_COMMENT) begin
        if (b == CHAR_LF || b == CHAR_CR) begin
          bump_line();
          mode = MODE_IDLE;
        end
      end else begin
        if (mode == MODE_IDENT) begin
          if (letter(b) || digit(b)) grow_run(b);
          else close_run();
        end else if (mode == MODE_NUMBER) begin
          if (digit(b) || b == CHAR_DOT) grow_run(b);
          else close_run();
        end
        if (mode == MODE_IDLE) begin
          if (blank(b)) begin
            if (b == CHAR_LF) bump_line();
          end else if (letter(b)) begin
            open_run(MODE_IDENT, b);
          end else if (digit(b) || b == CHAR_DOT) begin
            open_run(MODE_NUMBER, b);
          end else if (b == CHAR_HASH) begin
            mode = MODE_COMMENT;
          end else begin
            push_token(KIND_SINGLE, LIT_NONE, b, LENGTH_W'(1), pos, lines);
          end
        end
      end
      pos++;
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= 10)
        $display("%s", msg);
    endfunction

    function void check_token(token_t got);
      token_t exp;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected token: kind %0d start %0d", got.kind, got.start));
        return;
      end
      exp = awaited.pop_front();
      if (got.kind !== exp.kind || got.code !== exp.code || got.char_byte !== exp.char_byte ||
          got.length !== exp.length || got.start !== exp.start || got.line !== exp.line)
        report($sformatf({"token mismatch: expected kind %0d code %0d char %02h len %0d ",
                          "start %0d line %0d, got kind %0d code %0d char %02h len %0d ",
                          "start %0d line %0d"},
                         exp.kind, exp.code, exp.char_byte, exp.length, exp.start, exp.line,
                         got.kind, got.code, got.char_byte, got.length, got.start, got.line));
    endfunction
  endclass

  logic clk;
  logic rst;

  ets_char_if  char_if ();
  ets_token_if tok_if ();

  expression_token_scanner DUT (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_if),
    .token_out (tok_if)
  );

  token_scoreboard sb = new();
  int burst_left = 0;
  int items_sent = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'("a" + $urandom_range(0, 25));
    else return 8'("A" + $urandom_range(0, 25));
  endfunction

  function automatic logic [7:0] rand_alnum();
    if ($urandom_range(0, 2) == 0) return 8'("0" + $urandom_range(0, 9));
    else return rand_letter();
  endfunction

  task automatic drive_byte(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 40);
      if (gap > 0) begin
        @(negedge clk);
        char_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    char_if.valid        <= 1'b1;
    char_if.char_byte    <= b;
    char_if.end_of_input <= e;
    @(posedge clk);
    while (char_if.ready !== 1'b1) @(posedge clk);
    sb.note_input(b, e);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      drive_byte(s[i], 1'b0);
  endtask

  task automatic send_end();
    drive_byte(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Receiver: stall pattern switches between four modes after each random-length phase
  initial begin
    int  pat;
    int  phase_left;
    int  tick;
    logic r;
    pat = 0;
    phase_left = 0;
    tick = 0;
    tok_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (phase_left == 0) begin
        pat = $urandom_range(0, 3);
        phase_left = $urandom_range(16, 200);
      end
      phase_left--;
      tick++;
      case (pat)
        0:       r = 1'b1;
        1:       r = ($urandom_range(0, 3) != 0);
        2:       r = ($urandom_range(0, 3) == 0);
        default: r = ((tick % 16) >= 12);
      endcase
      tok_if.ready <= r;
    end
  end

  always @(posedge clk) begin
    token_t got;
    if (rst === 1'b0 && tok_if.valid === 1'b1 && tok_if.ready === 1'b1) begin
      got.kind      = token_kind_t'(tok_if.token_kind);
      got.code      = lit_code_t'(tok_if.literal_code);
      got.char_byte = tok_if.token_char;
      got.length    = tok_if.token_length;
      got.start     = tok_if.start_offset;
      got.line      = tok_if.line_number;
      sb.check_token(got);
    end
  end

  initial begin
    int    pick;
    int    n;
    int    random_from;
    string s;
    string ops;
    string names[4];
    names = '{"I", "Pi", "Euler", "Catalan"};
    ops = "+-*/^(),=<>;[]!";
    rst = 1'b1;
    char_if.valid = 1'b0;
    char_if.char_byte = 8'h00;
    char_if.end_of_input = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Byte extremes, every literal, runs closed by a single char, a comment,
    // a newline and the end mark, comments closed by CR, LF and the end mark
    drive_byte(8'h00, 1'b0);
    drive_byte(8'hFF, 1'b0);
    send_text("Pi(I#x\rEuler\n3.5Catalan");
    send_end();
    send_text("#\n#");
    send_end();

    random_from = items_sent;
    while (items_sent < random_from + 1750) begin
      pick = $urandom_range(0, 99);
      if (pick < 20) begin
        drive_byte(rand_letter(), 1'b0);
        repeat ($urandom_range(0, 7)) drive_byte(rand_alnum(), 1'b0);
        if ($urandom_range(0, 1) == 0) drive_byte(CHAR_SPACE, 1'b0);
      end else if (pick < 35) begin
        s = names[$urandom_range(0, 3)];
        case ($urandom_range(0, 4))
          2: if (s.len() > 1) s = s.substr(0, s.len() - 2);
          3: s = {s, string'(rand_alnum())};
          4: if (s.len() > 1) s[$urandom_range(1, s.len() - 1)] = rand_letter();
          default: ;
        endcase
        send_text(s);
        if ($urandom_range(0, 1) == 0) drive_byte(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
      end else if (pick < 50) begin
        n = $urandom_range(1, 6);
        repeat (n) drive_byte(($urandom_range(0, 4) == 0) ? CHAR_DOT :
                              8'("0" + $urandom_range(0, 9)), 1'b0);
        if ($urandom_range(0, 1) == 0) drive_byte(CHAR_SPACE, 1'b0);
      end else if (pick < 65) begin
        drive_byte(ops[$urandom_range(0, ops.len() - 1)], 1'b0);
      end else if (pick < 80) begin
        case ($urandom_range(0, 5))
          0:       drive_byte(CHAR_SPACE, 1'b0);
          1:       drive_byte(8'h09, 1'b0);
          2:       drive_byte(CHAR_LF, 1'b0);
          3:       drive_byte(CHAR_CR, 1'b0);
          4:       drive_byte(8'h0B, 1'b0);
          default: drive_byte(8'h0C, 1'b0);
        endcase
      end else if (pick < 87) begin
        drive_byte(CHAR_HASH, 1'b0);
        repeat ($urandom_range(0, 6)) drive_byte(8'($urandom_range(0, 255)), 1'b0);
        case ($urandom_range(0, 2))
          0:       drive_byte(CHAR_LF, 1'b0);
          1:       drive_byte(CHAR_CR, 1'b0);
          default: send_end();
        endcase
      end else if (pick < 90) begin
        send_end();
      end else begin
        drive_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end

    @(negedge clk);
    char_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.failures == 0 && sb.awaited.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ets_pkg.sv
hdl/ets_char_if.sv
hdl/ets_token_if.sv
hdl/ets_lexer.sv
hdl/ets_result_queue.sv
hdl/expression_token_scanner.sv
bench/expression_token_scanner_tb.sv
